[hw/rtl/assert_macros.svh]
// Assertion shorthands for the checker file etf_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is held.
`define CHK_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("checker assertion failed");

// Clocked assertion that also holds during reset.
`define CHK_ASSERT_NR(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("checker assertion failed");

`endif

[hw/rtl/etf_pkg.sv]
package etf_pkg;

    // Datapath operations.
    localparam logic [3:0] OP_NONE   = 4'd0;
    localparam logic [3:0] OP_LOAD   = 4'd1;
    localparam logic [3:0] OP_XFORM  = 4'd2;
    localparam logic [3:0] OP_MUL    = 4'd3;
    localparam logic [3:0] OP_SQ     = 4'd4;
    localparam logic [3:0] OP_ADDC   = 4'd5;
    localparam logic [3:0] OP_DSUM   = 4'd6;
    localparam logic [3:0] OP_DIVLD  = 4'd7;
    localparam logic [3:0] OP_DIVSTP = 4'd8;
    localparam logic [3:0] OP_DIVWR  = 4'd9;
    localparam logic [3:0] OP_LWGT   = 4'd10;
    localparam logic [3:0] OP_LAM    = 4'd11;

    // Multiplier operand selects (SEL_C is cr on side a, ci on side b).
    localparam logic [1:0] SEL_X = 2'd0;
    localparam logic [1:0] SEL_Y = 2'd1;
    localparam logic [1:0] SEL_C = 2'd2;

    // Register indexes.
    localparam logic [2:0] REG_MAX_ITER = 3'd0;
    localparam logic [2:0] REG_VARIANT  = 3'd1;
    localparam logic [2:0] REG_JULIA_EN = 3'd2;
    localparam logic [2:0] REG_JULIA_RE = 3'd3;
    localparam logic [2:0] REG_JULIA_IM = 3'd4;

    // Variant codes.
    localparam logic [3:0] V_MANDEL   = 4'd1;
    localparam logic [3:0] V_PERP_MB  = 4'd2;
    localparam logic [3:0] V_SHIP     = 4'd3;
    localparam logic [3:0] V_PERP_BS  = 4'd4;
    localparam logic [3:0] V_TRICORN  = 4'd5;
    localparam logic [3:0] V_DOUBLE   = 4'd6;
    localparam logic [3:0] V_CELTIC   = 4'd7;
    localparam logic [3:0] V_PERP_CE  = 4'd8;
    localparam logic [3:0] V_BUFFALO  = 4'd9;
    localparam logic [3:0] V_PERP_BU  = 4'd10;
    localparam logic [3:0] V_INVERSE  = 4'd11;
    localparam logic [3:0] V_LAMBDA   = 4'd12;

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] asel;
        logic [1:0] bsel;
        logic [1:0] dst;
        logic       absx;
        logic       absy;
        logic       negy;
        logic       sel_y;
        logic       last;
    } etf_cmd_t;

    typedef struct packed {
        logic escaped;
        logic d_zero;
        logic div_done;
    } etf_status_t;

    function automatic etf_cmd_t etf_op(input logic [3:0] op, input logic sel_y);
        etf_cmd_t c;
        c = '0;
        c.op = op;
        c.sel_y = sel_y;
        return c;
    endfunction

    function automatic etf_cmd_t etf_mul(input logic [1:0] a, input logic [1:0] b,
                                         input logic [1:0] dst);
        etf_cmd_t c;
        c = '0;
        c.op = OP_MUL;
        c.asel = a;
        c.bsel = b;
        c.dst = dst;
        return c;
    endfunction

    function automatic etf_cmd_t etf_xf(input logic ax, input logic ay, input logic ny);
        etf_cmd_t c;
        c = '0;
        c.op = OP_XFORM;
        c.absx = ax;
        c.absy = ay;
        c.negy = ny;
        return c;
    endfunction

    // Complex square: x*x, y*y, x*y, then combine.
    function automatic etf_cmd_t etf_sq(input logic [3:0] i);
        etf_cmd_t c;
        unique case (i[1:0])
            2'd0:    c = etf_mul(SEL_X, SEL_X, 2'd0);
            2'd1:    c = etf_mul(SEL_Y, SEL_Y, 2'd1);
            2'd2:    c = etf_mul(SEL_X, SEL_Y, 2'd2);
            default: c = etf_op(OP_SQ, 1'b0);
        endcase
        return c;
    endfunction

    // Micro-program of one iteration step; v is already folded to 1..12.
    function automatic etf_cmd_t etf_ucode(input logic [3:0] v, input logic [3:0] pc);
        etf_cmd_t c;
        logic [3:0] len;
        unique case (v)
            V_PERP_MB, V_SHIP, V_PERP_BS, V_TRICORN: begin
                len = 4'd6;
                if (pc == 4'd0)
                    c = etf_xf(v == V_PERP_MB || v == V_SHIP, v == V_SHIP || v == V_PERP_BS,
                               v == V_PERP_MB || v == V_TRICORN);
                else if (pc < 4'd5) c = etf_sq(pc - 4'd1);
                else c = etf_op(OP_ADDC, 1'b0);
            end
            V_DOUBLE: begin
                len = 4'd11;
                if (pc == 4'd0) c = etf_xf(1'b1, 1'b0, 1'b0);
                else if (pc < 4'd5) c = etf_sq(pc - 4'd1);
                else if (pc == 4'd5) c = etf_op(OP_ADDC, 1'b0);
                else if (pc == 4'd6) c = etf_xf(1'b0, 1'b0, 1'b1);
                else c = etf_sq(pc - 4'd7);
            end
            V_CELTIC, V_PERP_CE, V_BUFFALO: begin
                len = 4'd6;
                if (pc < 4'd4) c = etf_sq(pc);
                else if (pc == 4'd4)
                    c = etf_xf(1'b1, v == V_BUFFALO, v == V_PERP_CE);
                else c = etf_op(OP_ADDC, 1'b0);
            end
            V_PERP_BU: begin
                len = 4'd7;
                if (pc == 4'd0) c = etf_xf(1'b0, 1'b1, 1'b0);
                else if (pc < 4'd5) c = etf_sq(pc - 4'd1);
                else if (pc == 4'd5) c = etf_xf(1'b1, 1'b0, 1'b0);
                else c = etf_op(OP_ADDC, 1'b0);
            end
            V_INVERSE: begin
                len = 4'd14;
                priority case (1'b1)
                    pc < 4'd4:   c = etf_sq(pc);
                    pc == 4'd4:  c = etf_mul(SEL_X, SEL_X, 2'd0);
                    pc == 4'd5:  c = etf_mul(SEL_Y, SEL_Y, 2'd1);
                    pc == 4'd6:  c = etf_op(OP_DSUM, 1'b0);
                    pc == 4'd7:  c = etf_op(OP_DIVLD, 1'b0);
                    pc == 4'd8:  c = etf_op(OP_DIVSTP, 1'b0);
                    pc == 4'd9:  c = etf_op(OP_DIVWR, 1'b0);
                    pc == 4'd10: c = etf_op(OP_DIVLD, 1'b1);
                    pc == 4'd11: c = etf_op(OP_DIVSTP, 1'b1);
                    pc == 4'd12: c = etf_op(OP_DIVWR, 1'b1);
                    default:     c = etf_op(OP_ADDC, 1'b0);
                endcase
            end
            V_LAMBDA: begin
                len = 4'd10;
                priority case (1'b1)
                    pc < 4'd4:  c = etf_sq(pc);
                    pc == 4'd4: c = etf_op(OP_LWGT, 1'b0);
                    pc == 4'd5: c = etf_mul(SEL_C, SEL_X, 2'd0);
                    pc == 4'd6: c = etf_mul(SEL_Y, SEL_C, 2'd1);
                    pc == 4'd7: c = etf_mul(SEL_X, SEL_C, 2'd2);
                    pc == 4'd8: c = etf_mul(SEL_C, SEL_Y, 2'd3);
                    default:    c = etf_op(OP_LAM, 1'b0);
                endcase
            end
            default: begin
                len = 4'd5;
                if (pc < 4'd4) c = etf_sq(pc);
                else c = etf_op(OP_ADDC, 1'b0);
            end
        endcase
        c.last = (pc == len - 4'd1);
        return c;
    endfunction

endpackage

[hw/rtl/etf_datapath.sv]
module etf_datapath
    import etf_pkg::*;
#(
    parameter int WORD_WIDTH = 32,
    parameter int FRAC_BITS  = 24
) (
    input  logic                aclk,
    input  etf_cmd_t            cmd,
    input  logic signed [31:0]  point_real,
    input  logic signed [31:0]  point_imag,
    input  logic                julia_enable,
    input  logic signed [31:0]  julia_real,
    input  logic signed [31:0]  julia_imag,
    output etf_status_t         status
);
    localparam int W  = WORD_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int SW = 2 * W + 36;
    localparam int NQ = W + F;
    localparam int CW = $clog2(NQ + 1);
    localparam int UP = (F >= 24) ? F - 24 : 0;
    localparam int DN = (F >= 24) ? 0 : 24 - F;
    localparam logic signed [SW-1:0] QMAX_X = (SW'(1) <<< (W - 1)) - SW'(1);
    localparam logic signed [SW-1:0] QMIN_X = -QMAX_X - SW'(1);
    localparam logic signed [W-1:0]  QMAX   = QMAX_X[W-1:0];
    localparam logic signed [W-1:0]  QMIN   = QMIN_X[W-1:0];
    localparam logic signed [SW-1:0] ONE_X  = SW'(1) <<< F;
    localparam logic signed [SW-1:0] ESC_X  = SW'(4) <<< F;
    localparam logic [CW-1:0]        NQ_C   = CW'(NQ);

    function automatic logic signed [W-1:0] sat(input logic signed [SW-1:0] v);
        if (v > QMAX_X) return QMAX;
        if (v < QMIN_X) return QMIN;
        return v[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] qneg(input logic signed [W-1:0] a);
        return (a == QMIN) ? QMAX : -a;
    endfunction

    function automatic logic signed [W-1:0] qabs(input logic signed [W-1:0] a);
        return a[W-1] ? qneg(a) : a;
    endfunction

    function automatic logic signed [W-1:0] qin(input logic signed [31:0] r);
        logic signed [SW-1:0] e;
        e = SW'(r);
        e = (e <<< UP) >>> DN;
        return sat(e);
    endfunction

    logic signed [W-1:0]   x_reg, y_reg, cr_reg, ci_reg, d_reg;
    logic signed [2*W-1:0] p_reg [4];
    logic [W-1:0]          rem_reg;
    logic [NQ-1:0]         q_reg;
    logic [CW-1:0]         cnt_reg;
    logic                  dneg_reg;

    logic signed [W-1:0]   opa, opb, nsel, qv;
    logic signed [2*W-1:0] prod;
    logic signed [SW-1:0]  absx, absy, qsx;
    logic [W:0]            rsh;
    logic                  qbit;
    logic [W-1:0]          nmag;

    always_comb begin
        unique case (cmd.asel)
            SEL_Y:   opa = y_reg;
            SEL_C:   opa = cr_reg;
            default: opa = x_reg;
        endcase
        unique case (cmd.bsel)
            SEL_Y:   opb = y_reg;
            SEL_C:   opb = ci_reg;
            default: opb = x_reg;
        endcase
        prod = opa * opb;
        // exact magnitude sum for the escape test
        absx = x_reg[W-1] ? -SW'(x_reg) : SW'(x_reg);
        absy = y_reg[W-1] ? -SW'(y_reg) : SW'(y_reg);
        nsel = cmd.sel_y ? y_reg : x_reg;
        nmag = nsel[W-1] ? W'(-SW'(nsel)) : nsel;
        rsh  = {rem_reg, q_reg[NQ-1]};
        qbit = (rsh >= {1'b0, d_reg});
        qsx  = $signed(SW'({1'b0, q_reg}));
        qv   = sat(dneg_reg ? -qsx : qsx);
    end

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            OP_LOAD: begin
                x_reg  <= qin(point_real);
                y_reg  <= qin(point_imag);
                cr_reg <= julia_enable ? qin(julia_real) : qin(point_real);
                ci_reg <= julia_enable ? qin(julia_imag) : qin(point_imag);
            end
            OP_XFORM: begin
                if (cmd.absx) x_reg <= qabs(x_reg);
                if (cmd.absy) y_reg <= qabs(y_reg);
                else if (cmd.negy) y_reg <= qneg(y_reg);
            end
            OP_MUL: p_reg[cmd.dst] <= prod;
            OP_SQ: begin
                x_reg <= sat((SW'(p_reg[0]) - SW'(p_reg[1])) >>> F);
                y_reg <= sat(SW'(p_reg[2]) >>> (F - 1));
            end
            OP_ADDC: begin
                x_reg <= sat(SW'(x_reg) + SW'(cr_reg));
                y_reg <= sat(SW'(y_reg) + SW'(ci_reg));
            end
            OP_DSUM:
                d_reg <= sat(SW'(sat(SW'(p_reg[0]) >>> F)) + SW'(sat(SW'(p_reg[1]) >>> F)));
            OP_DIVLD: begin
                dneg_reg <= nsel[W-1];
                q_reg    <= {nmag, F'(0)};
                rem_reg  <= '0;
                cnt_reg  <= '0;
            end
            OP_DIVSTP: begin
                if (cnt_reg != NQ_C) begin
                    rem_reg <= qbit ? W'(rsh - {1'b0, d_reg}) : rsh[W-1:0];
                    q_reg   <= {q_reg[NQ-2:0], qbit};
                    cnt_reg <= cnt_reg + CW'(1);
                end
            end
            OP_DIVWR: begin
                if (cmd.sel_y) y_reg <= qv;
                else x_reg <= qv;
            end
            OP_LWGT: begin
                x_reg <= sat(ONE_X - SW'(x_reg));
                y_reg <= qneg(y_reg);
            end
            OP_LAM: begin
                x_reg <= sat((SW'(p_reg[0]) - SW'(p_reg[1])) >>> F);
                y_reg <= sat((SW'(p_reg[2]) + SW'(p_reg[3])) >>> F);
            end
            default: ;
        endcase
    end

    assign status.escaped  = (absx + absy) > ESC_X;
    assign status.d_zero   = (d_reg == '0);
    assign status.div_done = (cnt_reg == NQ_C);

endmodule

[hw/rtl/etf_controller.sv]
module etf_controller
    import etf_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [3:0]   variant,
    input  logic [15:0]  max_iterations,
    input  etf_status_t  status,
    input  logic         out_free,
    output logic         out_load,
    output logic [16:0]  count,
    output etf_cmd_t     cmd
);
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_CHECK  = 2'd1;
    localparam logic [1:0] ST_RUN    = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]  state_reg, state_next;
    logic [3:0]  pc_reg, pc_next;
    logic [16:0] count_reg, count_next;
    logic        esc_reg, esc_next, dead_reg, dead_next;
    logic        esc_now, step_end;
    etf_cmd_t    ucmd;

    always_comb begin
        ucmd       = etf_ucode(variant, pc_reg);
        esc_now    = (count_reg > 17'(max_iterations)) || (!dead_reg && status.escaped);
        state_next = state_reg;
        pc_next    = pc_reg;
        count_next = count_reg;
        esc_next   = esc_reg;
        dead_next  = dead_reg;
        cmd        = etf_op(OP_NONE, 1'b0);
        step_end   = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd        = etf_op(OP_LOAD, 1'b0);
                    count_next = '0;
                    dead_next  = 1'b0;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                esc_next = esc_now;
                pc_next  = '0;
                if (dead_reg) step_end = 1'b1;
                else state_next = ST_RUN;
            end
            ST_RUN: begin
                if (ucmd.op == OP_DIVLD && status.d_zero) begin
                    // zero divisor: freeze z, escape only by the limit
                    dead_next = 1'b1;
                    step_end  = 1'b1;
                end else begin
                    cmd = ucmd;
                    if (ucmd.op == OP_DIVSTP && !status.div_done) begin
                        pc_next = pc_reg;
                    end else if (ucmd.last) begin
                        step_end = 1'b1;
                    end else begin
                        pc_next = pc_reg + 4'd1;
                    end
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (step_end) begin
            count_next = count_reg + 17'd1;
            state_next = (state_reg == ST_CHECK ? esc_now : esc_reg) ? ST_FINISH : ST_CHECK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            dead_reg  <= 1'b0;
            esc_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            dead_reg  <= dead_next;
            esc_reg   <= esc_next;
        end
        pc_reg    <= pc_next;
        count_reg <= count_next;
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign count    = count_reg;

endmodule

[hw/rtl/escape_time_fractal_iterator_unit.sv]
// Escape-time fractal iterator. Each input transfer carries one complex point
// (Q8.24); the block iterates z <- f(z) + c in the variant chosen by register
// fractal_variant (1 Mandelbrot .. 12 lambda; other codes run as Mandelbrot)
// and returns one output transfer with the iteration count. Before each step
// it tests |re|+|im| > 4 or count > max_iterations; the step still runs, so
// the count is one past detection (1 .. max_iterations+2). With julia_enable
// set, z starts at the point and c is the configured julia constant. All
// arithmetic is saturating signed fixed point, WORD_WIDTH bits with
// FRAC_BITS fraction bits. One item is processed at a time: a complex step
// is a short micro-program on a single shared multiplier, preceded by an
// escape-test state; the inverse variant's program also holds two serial
// divisions with WORD_WIDTH+FRAC_BITS quotient bits each. The iteration
// limit max_iterations resets to 50. A finished count waits in the output
// register, so the next point can be taken while it is still held. Write
// configuration only while idle.
module escape_time_fractal_iterator_unit
    import etf_pkg::*;
#(
    parameter int WORD_WIDTH = 32,
    parameter int FRAC_BITS  = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] point_real, [63:32] point_imag
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [16:0] iteration_count, rest zero
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata
);
    logic [15:0]        max_iter_reg;
    logic [3:0]         variant_reg;
    logic               julia_en_reg;
    logic signed [31:0] julia_re_reg, julia_im_reg;
    logic [3:0]         variant_eff;
    logic               out_valid_reg;
    logic [16:0]        out_count_reg;
    logic               out_load;
    logic [16:0]        count;
    etf_cmd_t           cmd;
    etf_status_t        status;

    // Configuration writes; unknown indexes are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_iter_reg <= 16'd50;
            variant_reg  <= V_MANDEL;
            julia_en_reg <= 1'b0;
            julia_re_reg <= 32'shFF000000;
            julia_im_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_MAX_ITER: max_iter_reg <= cfg_wdata[15:0];
                REG_VARIANT:  variant_reg  <= cfg_wdata[3:0];
                REG_JULIA_EN: julia_en_reg <= cfg_wdata[0];
                REG_JULIA_RE: julia_re_reg <= cfg_wdata;
                REG_JULIA_IM: julia_im_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Fold codes that name no formula onto Mandelbrot.
    assign variant_eff = (variant_reg == 4'd0 || variant_reg > V_LAMBDA) ? V_MANDEL
                                                                         : variant_reg;

    etf_controller u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .variant        (variant_eff),
        .max_iterations (max_iter_reg),
        .status         (status),
        .out_free       (!out_valid_reg || m_tready),
        .out_load       (out_load),
        .count          (count),
        .cmd            (cmd)
    );

    etf_datapath #(
        .WORD_WIDTH (WORD_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .aclk         (aclk),
        .cmd          (cmd),
        .point_real   (s_tdata[31:0]),
        .point_imag   (s_tdata[63:32]),
        .julia_enable (julia_en_reg),
        .julia_real   (julia_re_reg),
        .julia_imag   (julia_im_reg),
        .status       (status)
    );

    // Output register: hold the count until the transfer completes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (out_load) out_count_reg <= count;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_count_reg};

endmodule

[hw/rtl/etf_checker.sv]
`include "assert_macros.svh"
module etf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);
    `CHK_ASSERT_NR(a_no_result_after_reset, aclk, !aresetn |=> !m_tvalid)
    `CHK_ASSERT(a_busy_after_accept, aclk, aresetn, (s_tvalid && s_tready) |=> !s_tready)
    `CHK_ASSERT(a_count_nonzero, aclk, aresetn, m_tvalid |-> (m_tdata[16:0] != 17'd0))
    `CHK_ASSERT(a_result_held, aclk, aresetn,
                (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
endmodule

bind escape_time_fractal_iterator_unit etf_checker u_etf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
